>>> src/mslru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslru_pkg
// Shared types and constants of the multi-size LRU miss counter.
// ----------------------------------------------------------------------------
package mslru_pkg;

    // Register map of the configuration port.
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 7;
    localparam int COUNT_W        = 3;
    localparam int CAP_W          = 7;
    localparam int CAP_REGS       = 4;
    localparam int IDX_W          = 2;
    localparam int ADDR_W         = 32;
    localparam int MISS_W         = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CACHE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_0  = 3'd1;

    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_ENCODE,
        S_UPDATE,
        S_REPORT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             latch_in;
        logic             match;
        logic             encode;
        logic             update;
        logic             load_out;
        logic [IDX_W-1:0] rep_idx;
        logic             rep_last;
        logic             clear_counts;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [COUNT_W-1:0] active;
        logic               out_free;
    } t_status;

endpackage

>>> src/multi_size_lru_miss_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_size_lru_miss_counter
// Stack-distance profiler that counts misses of up to four fully associative
// LRU caches of different sizes from one shared recency stack.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------
//  request   in         i_in_valid / o_in_ready   i_action, i_address
//  result    out        o_out_valid / i_out_ready o_cache_index, o_miss_total,
//                                                 o_last_of_run
//  config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// An access request is accepted in S_IDLE, then steps through S_MATCH, in
// which every stack cell compares its address, S_ENCODE, which encodes the
// hit depth, and S_UPDATE, which shifts the stack and bumps the miss counters.
// A report request is accepted and then loads one result per active cache,
// waiting whenever the result register is stalled by the consumer.
// Reset (synchronous, active low) empties the stack, clears the counters and
// sets one cache of capacity one; no clearing pass is needed afterwards.
// A waiting result never blocks the next access: the result register holds it
// while the stack keeps working.
//
module multi_size_lru_miss_counter
    import mslru_pkg::*;
#(
    parameter int NUM_CACHES  = 4,
    parameter int STACK_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [ADDR_W-1:0]     i_address,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IDX_W-1:0]      o_cache_index,
    output logic [MISS_W-1:0]     o_miss_total,
    output logic                  o_last_of_run,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_is_access;

    // The address is only captured for access requests; reports ignore it.
    assign w_is_access = (i_action == ACT_ACCESS);

    // The controller sequences requests; it never sees the address.
    mslru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the stack, the counters and the result register.
    mslru_dp #(
        .NUM_CACHES  (NUM_CACHES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_address_in  (w_is_access),
        .i_address     (i_address),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_cache_index (o_cache_index),
        .o_miss_total  (o_miss_total),
        .o_last_of_run (o_last_of_run)
    );

    // A new result is never written over one the consumer has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out_valid && !i_out_ready))
        else $error("result register overwritten while stalled");

    // An access holds off new requests in its match, encode and update states.
    a_access_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == ACT_ACCESS)
        |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("request accepted during an access");

    // The last result of a report ends the report: counters clear with it.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && w_cmd.rep_last) |-> w_cmd.clear_counts)
        else $error("report ended without clearing the counters");

    // No result is produced after the last one of a report.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && w_cmd.rep_last) |=> !w_cmd.load_out)
        else $error("result produced after the last of a report");

endmodule

>>> src/mslru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslru_ctrl
// Sequencer that steps an access through match, encode and shift, and
// walks the miss counters out on a report.
// ----------------------------------------------------------------------------
module mslru_ctrl
    import mslru_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_action,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_rep_idx, n_rep_idx;
    logic             w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rep_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_rep_idx <= n_rep_idx;
        end
    end

    assign w_last = ({1'b0, r_rep_idx} + COUNT_W'(1)) == i_status.active;

    always_comb begin
        n_state    = r_state;
        n_rep_idx  = r_rep_idx;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rep_idx  = r_rep_idx;
        o_cmd.rep_last = w_last;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) begin
                    if (i_action == ACT_ACCESS) begin
                        n_state = S_MATCH;
                    end else if (i_status.active == '0) begin
                        // No cache in use: nothing to send, just clear.
                        o_cmd.clear_counts = 1'b1;
                    end else begin
                        n_state   = S_REPORT;
                        n_rep_idx = '0;
                    end
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_ENCODE;
            end
            S_ENCODE: begin
                o_cmd.encode = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (w_last) begin
                        o_cmd.clear_counts = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_rep_idx = r_rep_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/mslru_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslru_dp
// Datapath: configuration registers, recency stack cells, depth encoder,
// miss counters and the result register.
// ----------------------------------------------------------------------------
module mslru_dp
    import mslru_pkg::*;
#(
    parameter int NUM_CACHES  = 4,
    parameter int STACK_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_address_in,
    input  logic [ADDR_W-1:0]     i_address,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [IDX_W-1:0]      o_cache_index,
    output logic [MISS_W-1:0]     o_miss_total,
    output logic                  o_last_of_run
);

    localparam int DEPTH_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FILL_W     = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W      = (DEPTH_W > CAP_W) ? DEPTH_W : CAP_W;
    localparam int ACTIVE_MAX = (NUM_CACHES < CAP_REGS) ? NUM_CACHES : CAP_REGS;

    logic [COUNT_W-1:0] r_cache_count;
    logic [CAP_W-1:0]   r_capacity [CAP_REGS];

    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W-1:0]      r_stack [STACK_DEPTH];
    logic [FILL_W-1:0]      r_fill;
    logic [STACK_DEPTH-1:0] r_hit;
    logic [DEPTH_W-1:0]     r_depth;
    logic                   r_found;
    logic [MISS_W-1:0]      r_miss [NUM_CACHES];

    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_index;
    logic [MISS_W-1:0]      r_out_total;
    logic                   r_out_last;

    logic [COUNT_W-1:0]     w_active;
    logic [DEPTH_W-1:0]     w_enc;
    logic [DEPTH_W-1:0]     w_shift_depth;
    logic                   w_not_full;
    logic [NUM_CACHES-1:0]  w_miss;
    logic [MISS_W-1:0]      w_sel_total;

    // Configuration registers; writes beyond the register map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_count <= COUNT_W'(1);
            for (int i = 0; i < CAP_REGS; i++) begin
                r_capacity[i] <= CAP_W'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_CACHE_COUNT) begin
                r_cache_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index >= REG_CAPACITY_0 &&
                         i_cfg_index < REG_CAPACITY_0 + CFG_IDX_W'(CAP_REGS)) begin
                r_capacity[IDX_W'(i_cfg_index - REG_CAPACITY_0)] <= i_cfg_data;
            end
        end
    end

    assign w_active = (r_cache_count > COUNT_W'(ACTIVE_MAX)) ? COUNT_W'(ACTIVE_MAX)
                                                             : r_cache_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in && i_address_in) begin
            r_addr <= i_address;
        end
    end

    // Every cell compares its own entry; entries below the fill level only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                r_hit[i] <= (FILL_W'(i) < r_fill) && (r_stack[i] == r_addr);
            end
        end
    end

    // Stored addresses are distinct, so the hit vector is one-hot or empty.
    always_comb begin
        w_enc = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (r_hit[i]) begin
                w_enc = w_enc | DEPTH_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.encode) begin
            r_depth <= w_enc;
            r_found <= |r_hit;
        end
    end

    assign w_not_full = r_fill < FILL_W'(STACK_DEPTH);

    always_comb begin
        if (r_found) begin
            w_shift_depth = r_depth;
        end else if (w_not_full) begin
            w_shift_depth = r_fill[DEPTH_W-1:0];
        end else begin
            w_shift_depth = DEPTH_W'(STACK_DEPTH - 1);
        end
    end

    // Move-to-front: cells 1 up to the shift depth take their upper neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_stack[0] <= r_addr;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                if (DEPTH_W'(i) <= w_shift_depth) begin
                    r_stack[i] <= r_stack[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.update && !r_found && w_not_full) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CACHES; i++) begin
            w_miss[i] = (COUNT_W'(i) < w_active) &&
                        (!r_found ||
                         CMP_W'(r_capacity[IDX_W'(i)]) <= CMP_W'(r_depth));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_counts) begin
            for (int i = 0; i < NUM_CACHES; i++) begin
                r_miss[i] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < NUM_CACHES; i++) begin
                if (w_miss[i] && r_miss[i] != '1) begin
                    r_miss[i] <= r_miss[i] + MISS_W'(1);
                end
            end
        end
    end

    always_comb begin
        w_sel_total = '0;
        for (int i = 0; i < ACTIVE_MAX; i++) begin
            if (i_cmd.rep_idx == IDX_W'(i)) begin
                w_sel_total = r_miss[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_index <= i_cmd.rep_idx;
            r_out_total <= w_sel_total;
            r_out_last  <= i_cmd.rep_last;
        end
    end

    assign o_status.active   = w_active;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_cache_index = r_out_index;
    assign o_miss_total  = r_out_total;
    assign o_last_of_run = r_out_last;

endmodule
